>>> sv/gpw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpw_pkg
// Shared types and constants for the grid path to waypoint converter.
// ----------------------------------------------------------------------------
package gpw_pkg;

    localparam int OUT_BITS   = 20;
    localparam int CFG_BITS   = 8;
    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CELL_SIZE = 1'b0,
        CFG_HALF_CELL = 1'b1
    } cfg_idx_t;

    localparam logic [CFG_BITS-1:0] CELL_SIZE_RST = 8'd32;
    localparam logic [CFG_BITS-1:0] HALF_CELL_RST = 8'd16;

    localparam logic KIND_CORNER = 1'b0;
    localparam logic KIND_CENTER = 1'b1;

    typedef struct packed {
        logic [CFG_BITS-1:0] cell_size;
        logic [CFG_BITS-1:0] half_cell;
    } cfg_t;

endpackage
`default_nettype wire

>>> sv/gpw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpw_queue
// Four-entry step queue between the front and back ends.
// ----------------------------------------------------------------------------
module gpw_queue #(
    parameter int WIDTH = 50
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == (PTR_BITS+1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/gpw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpw_front
// Accepts path cells, tracks the two previous cells and decides which steps
// are kept; kept steps go to the queue one per cycle while it is not full.
// ----------------------------------------------------------------------------
module gpw_front #(
    parameter int CELL_COORD_BITS = 12
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [CELL_COORD_BITS-1:0] cell_x,
    input  wire logic [CELL_COORD_BITS-1:0] cell_y,
    input  wire logic                       is_last,
    input  wire logic                       q_full,
    output logic                            push_valid,
    output logic [4*CELL_COORD_BITS+1:0]    push_data
);
    localparam int N = CELL_COORD_BITS;

    typedef struct packed {
        logic [N-1:0] corner_x;
        logic [N-1:0] corner_y;
        logic [N-1:0] to_x;
        logic [N-1:0] to_y;
        logic         diag;
        logic         last;
    } step_t;

    logic [N-1:0] prev_x_reg;
    logic [N-1:0] prev_y_reg;
    logic [N-1:0] older_x_reg;
    logic [N-1:0] older_y_reg;
    logic [1:0]   cells_seen_reg;
    logic         pend_valid_reg;
    step_t        pend_reg;

    logic         acc;
    logic         same_delta;
    logic         a_valid;
    logic         b_valid;
    step_t        a_step;
    step_t        b_step;
    logic [N:0]   d1x;
    logic [N:0]   d1y;
    logic [N:0]   d2x;
    logic [N:0]   d2y;

    assign in_stall = pend_valid_reg || q_full;
    assign acc      = in_valid && !in_stall;

    always_comb
    begin
        d1x = {1'b0, prev_x_reg} - {1'b0, older_x_reg};
        d1y = {1'b0, prev_y_reg} - {1'b0, older_y_reg};
        d2x = {1'b0, cell_x} - {1'b0, prev_x_reg};
        d2y = {1'b0, cell_y} - {1'b0, prev_y_reg};
        same_delta = (d1x == d2x) && (d1y == d2y);
        a_valid = (cells_seen_reg >= 2'd2) && !((cells_seen_reg == 2'd3) && same_delta);
        b_valid = is_last && (cells_seen_reg != 2'd0);

        a_step.corner_x = (older_x_reg > prev_x_reg) ? older_x_reg : prev_x_reg;
        a_step.corner_y = (older_y_reg > prev_y_reg) ? older_y_reg : prev_y_reg;
        a_step.to_x     = prev_x_reg;
        a_step.to_y     = prev_y_reg;
        a_step.diag     = (older_x_reg != prev_x_reg) && (older_y_reg != prev_y_reg);
        a_step.last     = 1'b0;

        b_step.corner_x = (prev_x_reg > cell_x) ? prev_x_reg : cell_x;
        b_step.corner_y = (prev_y_reg > cell_y) ? prev_y_reg : cell_y;
        b_step.to_x     = cell_x;
        b_step.to_y     = cell_y;
        b_step.diag     = (prev_x_reg != cell_x) && (prev_y_reg != cell_y);
        b_step.last     = 1'b1;
    end

    assign push_valid = pend_valid_reg || (acc && (a_valid || b_valid));
    assign push_data  = pend_valid_reg ? pend_reg : (a_valid ? a_step : b_step);

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pend_reg <= b_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            older_x_reg    <= '0;
            older_y_reg    <= '0;
            cells_seen_reg <= 2'd0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pend_valid_reg && !q_full)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (acc)
            begin
                pend_valid_reg <= a_valid && b_valid;
                older_x_reg    <= prev_x_reg;
                older_y_reg    <= prev_y_reg;
                prev_x_reg     <= cell_x;
                prev_y_reg     <= cell_y;
                if (is_last)
                begin
                    cells_seen_reg <= 2'd0;
                end
                else if (cells_seen_reg != 2'd3)
                begin
                    cells_seen_reg <= cells_seen_reg + 2'd1;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/gpw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpw_back
// Turns queued steps into waypoints: corner point for diagonal steps, then
// the scaled cell centre. Multiply stage, then offset added in the output register.
// ----------------------------------------------------------------------------
module gpw_back #(
    parameter int CELL_COORD_BITS = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gpw_pkg::cfg_t                cfg,
    input  wire logic                         q_valid,
    input  wire logic [4*CELL_COORD_BITS+1:0] q_data,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [gpw_pkg::OUT_BITS-1:0]      out_x,
    output logic [gpw_pkg::OUT_BITS-1:0]      out_y,
    output logic                              point_kind,
    output logic                              last_of_path
);
    import gpw_pkg::*;

    localparam int N        = CELL_COORD_BITS;
    localparam int MUL_BITS = (N + CFG_BITS > OUT_BITS) ? N + CFG_BITS : OUT_BITS;

    typedef struct packed {
        logic [N-1:0] corner_x;
        logic [N-1:0] corner_y;
        logic [N-1:0] to_x;
        logic [N-1:0] to_y;
        logic         diag;
        logic         last;
    } step_t;

    typedef enum logic {
        PH_CORNER,
        PH_CENTER
    } phase_t;

    step_t                cur_reg;
    logic                 cur_valid_reg;
    phase_t               phase_reg;

    logic                 prod_valid_reg;
    logic [OUT_BITS-1:0]  prod_x_reg;
    logic [OUT_BITS-1:0]  prod_y_reg;
    logic                 prod_kind_reg;
    logic                 prod_last_reg;

    logic                 out_valid_reg;
    logic [OUT_BITS-1:0]  out_x_reg;
    logic [OUT_BITS-1:0]  out_y_reg;
    logic                 out_kind_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 prod_free;
    logic                 emit;
    logic                 emit_corner;
    logic                 cur_done;
    logic [N-1:0]         sel_x;
    logic [N-1:0]         sel_y;
    logic [MUL_BITS-1:0]  mul_x;
    logic [MUL_BITS-1:0]  mul_y;
    logic [OUT_BITS-1:0]  offset;

    assign out_free    = !out_valid_reg || !out_stall;
    assign prod_free   = !prod_valid_reg || out_free;
    assign emit        = cur_valid_reg && prod_free;
    assign emit_corner = cur_reg.diag && (phase_reg == PH_CORNER);
    assign cur_done    = emit && !emit_corner;
    assign q_pop       = q_valid && (!cur_valid_reg || cur_done);

    assign sel_x = emit_corner ? cur_reg.corner_x : cur_reg.to_x;
    assign sel_y = emit_corner ? cur_reg.corner_y : cur_reg.to_y;
    assign mul_x = MUL_BITS'(sel_x) * MUL_BITS'(cfg.cell_size);
    assign mul_y = MUL_BITS'(sel_y) * MUL_BITS'(cfg.cell_size);
    assign offset = (prod_kind_reg == KIND_CENTER) ? OUT_BITS'(cfg.half_cell) : '0;

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign point_kind   = out_kind_reg;
    assign last_of_path = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (prod_free)
        begin
            prod_x_reg    <= mul_x[OUT_BITS-1:0];
            prod_y_reg    <= mul_y[OUT_BITS-1:0];
            prod_kind_reg <= emit_corner ? KIND_CORNER : KIND_CENTER;
            prod_last_reg <= !emit_corner && cur_reg.last;
        end
        if (out_free)
        begin
            out_x_reg    <= prod_x_reg + offset;
            out_y_reg    <= prod_y_reg + offset;
            out_kind_reg <= prod_kind_reg;
            out_last_reg <= prod_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            phase_reg      <= PH_CORNER;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                phase_reg     <= PH_CORNER;
            end
            else if (cur_done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                phase_reg <= PH_CENTER;
            end
            if (prod_free)
            begin
                prod_valid_reg <= emit;
            end
            if (out_free)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/grid_path_to_waypoints_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_path_to_waypoints_core
// Throughput: one item per cycle into a 4-entry step queue while in_stall is low;
// a last cell that settles two steps stalls input while its second is pushed.
// The back end emits one waypoint per cycle unless out_stall (one waypoint per
// straight step, two per diagonal), which sets the sustained rate.
// Reset: async active-low; clears path history, queue and pipeline valids,
// cell_size to 32 and half_cell to 16.
// ----------------------------------------------------------------------------
module grid_path_to_waypoints_core #(
    parameter int CELL_COORD_BITS = 12
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [gpw_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [gpw_pkg::CFG_BITS-1:0]     cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [CELL_COORD_BITS-1:0]       cell_x,
    input  wire logic [CELL_COORD_BITS-1:0]       cell_y,
    input  wire logic                             is_last,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [gpw_pkg::OUT_BITS-1:0]          out_x,
    output logic [gpw_pkg::OUT_BITS-1:0]          out_y,
    output logic                                  point_kind,
    output logic                                  last_of_path
);
    import gpw_pkg::*;

    localparam int STEP_BITS = 4 * CELL_COORD_BITS + 2;

    cfg_t                 cfg_reg;
    logic                 q_full;
    logic                 push_valid;
    logic [STEP_BITS-1:0] push_data;
    logic                 q_pop;
    logic                 q_valid;
    logic [STEP_BITS-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_size <= CELL_SIZE_RST;
            cfg_reg.half_cell <= HALF_CELL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CELL_SIZE: cfg_reg.cell_size <= cfg_data;
                CFG_HALF_CELL: cfg_reg.half_cell <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    gpw_front #(
        .CELL_COORD_BITS(CELL_COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .is_last    (is_last),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    gpw_queue #(
        .WIDTH(STEP_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    gpw_back #(
        .CELL_COORD_BITS(CELL_COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .point_kind   (point_kind),
        .last_of_path (last_of_path)
    );

endmodule
`default_nettype wire
